FILE: src/smrmc_pkg.sv
// Shared codes, register indexes and types for the sumo robot mode controller.
package smrmc_pkg;

    // Phase codes.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_COUNT  = 2'd1;
    localparam logic [1:0] PH_ACTIVE = 2'd2;
    localparam logic [1:0] PH_REV    = 2'd3;

    // Mode codes.
    localparam logic [2:0] M_ATTACK  = 3'd0;
    localparam logic [2:0] M_SEARCH  = 3'd1;
    localparam logic [2:0] M_BACK    = 3'd2;
    localparam logic [2:0] M_LEFT    = 3'd3;
    localparam logic [2:0] M_LEFT45  = 3'd4;
    localparam logic [2:0] M_RIGHT   = 3'd5;
    localparam logic [2:0] M_RIGHT45 = 3'd6;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_ON     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 3'd6;

    // Distance sensor lanes, in the order they are packed on the input stream.
    localparam int DI_CENTER  = 0;
    localparam int DI_LEFT    = 1;
    localparam int DI_LEFT45  = 2;
    localparam int DI_RIGHT45 = 3;
    localparam int DI_RIGHT   = 4;
    localparam int NUM_DIST   = 5;

    localparam int THR_BITS = 12;

    // Register reset values.
    localparam logic [THR_BITS-1:0] RST_THRESHOLD  = 12'd2000;
    localparam logic [7:0]          RST_SPEED_MAX  = 8'd160;
    localparam logic [7:0]          RST_SPEED_BASE = 8'd140;
    localparam logic [7:0]          RST_SPEED_MIN  = 8'd120;
    localparam logic [15:0]         RST_LED_ON     = 16'd3000;
    localparam logic [15:0]         RST_START      = 16'd5000;
    localparam logic [9:0]          RST_REVERSE    = 10'd100;

    typedef struct packed {
        logic [THR_BITS-1:0] threshold;
        logic [7:0]          speed_max;
        logic [7:0]          speed_base;
        logic [7:0]          speed_min;
        logic [15:0]         led_on_ms;
        logic [15:0]         start_ms;
        logic [9:0]          reverse_ms;
    } t_cfg;

    // Result item; the last member sits in the lowest bits of the stream word.
    typedef struct packed {
        logic [2:0] mode_now;
        logic [1:0] phase_now;
        logic       warning_led;
        logic [8:0] right_drive;
        logic [8:0] left_drive;
    } t_result;

endpackage

FILE: src/smrmc_cfg_regs.sv
// Configuration register file for the sumo robot mode controller.
module smrmc_cfg_regs
    import smrmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Each write updates one register; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold  <= RST_THRESHOLD;
            r_cfg.speed_max  <= RST_SPEED_MAX;
            r_cfg.speed_base <= RST_SPEED_BASE;
            r_cfg.speed_min  <= RST_SPEED_MIN;
            r_cfg.led_on_ms  <= RST_LED_ON;
            r_cfg.start_ms   <= RST_START;
            r_cfg.reverse_ms <= RST_REVERSE;
        end else if (i_wr) begin
            case (i_index)
                CFG_THRESHOLD:  r_cfg.threshold  <= i_data[THR_BITS-1:0];
                CFG_SPEED_MAX:  r_cfg.speed_max  <= i_data[7:0];
                CFG_SPEED_BASE: r_cfg.speed_base <= i_data[7:0];
                CFG_SPEED_MIN:  r_cfg.speed_min  <= i_data[7:0];
                CFG_LED_ON:     r_cfg.led_on_ms  <= i_data[15:0];
                CFG_START:      r_cfg.start_ms   <= i_data[15:0];
                CFG_REVERSE:    r_cfg.reverse_ms <= i_data[9:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/smrmc_core.sv
// Controller state and its one-tick update for the sumo robot mode controller.
module smrmc_core
    import smrmc_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_step,
    input  t_cfg                               i_cfg,
    input  logic                               i_button,
    input  logic [NUM_DIST-1:0][ADC_BITS-1:0]  i_dist,
    input  logic                               i_line_rear,
    input  logic                               i_line_left,
    input  logic                               i_line_right,
    output t_result                            o_result
);

    localparam int CW = (ADC_BITS > THR_BITS) ? ADC_BITS : THR_BITS;

    logic [1:0]  r_phase,   n_phase;
    logic [15:0] r_elapsed, n_elapsed;
    logic [2:0]  r_mode,    n_mode;
    logic [9:0]  r_rev,     n_rev;
    logic [2:0]  r_pend,    n_pend;
    logic [8:0]  r_left,    n_left;
    logic [8:0]  r_right,   n_right;
    logic        r_led,     n_led;

    logic [NUM_DIST-1:0] seen;
    logic [15:0] elapsed_inc;
    logic [2:0]  sel_mode;
    logic [9:0]  rev_load;
    logic [9:0]  rev_src;
    logic [9:0]  rev_dec;
    logic [8:0]  drv_max, drv_base, drv_min, drv_rev;

    // Opponent detection per distance lane.
    always_comb begin
        for (int i = 0; i < NUM_DIST; i++) begin
            seen[i] = CW'(i_dist[i]) >= CW'(i_cfg.threshold);
        end
    end

    assign elapsed_inc = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
    assign drv_max  = {1'b0, i_cfg.speed_max};
    assign drv_base = {1'b0, i_cfg.speed_base};
    assign drv_min  = {1'b0, i_cfg.speed_min};
    assign drv_rev  = 9'd0 - drv_min;
    assign rev_load = (i_cfg.reverse_ms == 10'd0) ? 10'd1 : i_cfg.reverse_ms;

    // Reverse counter source: running count while reversing, fresh load on an edge.
    assign rev_src = (r_phase == PH_REV) ? r_rev : rev_load;
    assign rev_dec = (rev_src != 10'd0) ? rev_src - 10'd1 : 10'd0;

    // Mode choice by sensor priority, then line-edge overrides.
    always_comb begin
        sel_mode = r_mode;
        if (seen[DI_CENTER]) begin
            sel_mode = M_ATTACK;
        end else if (seen[DI_LEFT]) begin
            sel_mode = M_LEFT;
        end else if (seen[DI_RIGHT]) begin
            sel_mode = M_RIGHT;
        end else if (seen[DI_LEFT45]) begin
            sel_mode = M_LEFT45;
        end else if (seen[DI_RIGHT45]) begin
            sel_mode = M_RIGHT45;
        end
        if (i_line_left || i_line_right) begin
            sel_mode = M_BACK;
        end else if (i_line_rear) begin
            sel_mode = M_ATTACK;
        end
    end

    // Next state for one tick.
    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_mode    = r_mode;
        n_rev     = r_rev;
        n_pend    = r_pend;
        n_left    = r_left;
        n_right   = r_right;
        n_led     = r_led;
        case (r_phase)
            PH_IDLE: begin
                if (i_button) begin
                    n_elapsed = 16'd0;
                    n_phase   = PH_COUNT;
                    n_led     = 1'b0;
                end
            end
            PH_COUNT: begin
                n_elapsed = elapsed_inc;
                n_led = (elapsed_inc >= i_cfg.led_on_ms) && (elapsed_inc < i_cfg.start_ms);
                if (elapsed_inc >= i_cfg.start_ms) begin
                    n_phase = PH_ACTIVE;
                    n_led   = 1'b0;
                end
                n_left  = 9'd0;
                n_right = 9'd0;
            end
            PH_REV: begin
                n_rev = rev_dec;
                if (rev_dec == 10'd0) begin
                    n_mode  = r_pend;
                    n_phase = PH_ACTIVE;
                end else begin
                    n_mode  = M_BACK;
                    n_phase = PH_REV;
                end
                n_left  = drv_rev;
                n_right = drv_rev;
            end
            default: begin
                n_mode = sel_mode;
                case (sel_mode)
                    M_SEARCH, M_RIGHT: begin
                        n_left  = drv_min;
                        n_right = drv_max;
                    end
                    M_RIGHT45: begin
                        n_left  = drv_base;
                        n_right = drv_max;
                    end
                    M_LEFT: begin
                        n_left  = drv_max;
                        n_right = drv_min;
                    end
                    M_LEFT45: begin
                        n_left  = drv_max;
                        n_right = drv_base;
                    end
                    M_ATTACK: begin
                        n_left  = drv_max;
                        n_right = drv_max;
                    end
                    M_BACK: begin
                        // The side to search afterwards is fixed at the edge.
                        n_pend = i_line_rear ? M_LEFT : M_RIGHT;
                        n_rev  = rev_dec;
                        if (rev_dec == 10'd0) begin
                            n_mode  = n_pend;
                            n_phase = PH_ACTIVE;
                        end else begin
                            n_mode  = M_BACK;
                            n_phase = PH_REV;
                        end
                        n_left  = drv_rev;
                        n_right = drv_rev;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    // State registers advance once per tick item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= 16'd0;
            r_mode    <= M_SEARCH;
            r_rev     <= 10'd0;
            r_pend    <= M_SEARCH;
            r_left    <= 9'd0;
            r_right   <= 9'd0;
            r_led     <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_mode    <= n_mode;
            r_rev     <= n_rev;
            r_pend    <= n_pend;
            r_left    <= n_left;
            r_right   <= n_right;
            r_led     <= n_led;
        end
    end

    // The result of a tick is the state after it.
    assign o_result.left_drive  = n_left;
    assign o_result.right_drive = n_right;
    assign o_result.warning_led = n_led;
    assign o_result.phase_now   = n_phase;
    assign o_result.mode_now    = n_mode;

endmodule

FILE: src/sumo_robot_mode_controller_unit.sv
// Top level of the sumo robot mode controller: stream ports, item and result registers.
//
// Usage: one input transaction carries one millisecond tick: the start button,
// five distance samples and three line flags. Each tick gives exactly one result
// transaction with the signed wheel drives, the warning LED, the phase and the mode.
// Configuration registers are written over the cfg channel (index, data), which is
// always ready; write them only while no tick is in flight.
// A tick accepted on the slave side is held in the input register and processed by
// the state update when it advances, which also loads the result register, so the
// result is shown on the master side from the result register. Throughput is one
// tick per cycle while the receiver takes results; the state update is a single
// registered pass, so ticks may follow back to back.
// Reset (synchronous, active low) puts the controller in the idle phase with zero
// drives, search mode and the default register values; no clearing pass is needed.
// When the receiver stalls, the result register holds its transaction and the input
// register still takes one more tick; after that the slave side deasserts tready.
module sumo_robot_mode_controller_unit
    import smrmc_pkg::*;
#(
    parameter int ADC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Tick input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // Fields from bit 0 up: start_button, dist_center, dist_left, dist_left45,
    // dist_right45, dist_right, line_rear, line_left, line_right, zero fill.
    input  logic [((4+5*ADC_BITS+7)/8)*8-1:0] i_s_tdata,
    // Result output stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // Fields from bit 0 up: left_drive, right_drive, warning_led, phase_now, mode_now.
    output logic [23:0]           o_m_tdata,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LINE_LSB = 1 + NUM_DIST * ADC_BITS;
    localparam int IN_BITS  = LINE_LSB + 3;

    logic               r_in_valid;
    logic [IN_BITS-1:0] r_in_data;
    logic               r_out_valid;
    t_result            r_out;
    t_result            result;
    t_cfg               cfg;
    logic               s_fire;
    logic               advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    smrmc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    smrmc_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_cfg        (cfg),
        .i_button     (r_in_data[0]),
        .i_dist       (r_in_data[LINE_LSB-1:1]),
        .i_line_rear  (r_in_data[LINE_LSB]),
        .i_line_left  (r_in_data[LINE_LSB+1]),
        .i_line_right (r_in_data[LINE_LSB+2]),
        .o_result     (result)
    );

    // Input item register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_fire || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_data <= i_s_tdata[IN_BITS-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !i_m_tready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

`ifndef ASSERT_OFF
    // A reversing tick always reports the back mode.
    a_rev_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (result.phase_now == PH_REV) |-> result.mode_now == M_BACK)
        else $error("reversing phase without back mode");

    // Countdown ticks never drive the wheels.
    a_count_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (result.phase_now == PH_COUNT)
            |-> (result.left_drive == 9'd0) && (result.right_drive == 9'd0))
        else $error("wheels driven during countdown");

    // A processed tick always leaves a result waiting on the master side.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed tick produced no result");
`endif

endmodule
